[design/pic_pkg.sv]
package pic_pkg;

  localparam int DEF_NUM_SOURCES   = 32;
  localparam int DEF_PRIORITY_BITS = 3;

  // Item kinds on the input channel. Code 3 is a no-op.
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // Register map (byte offsets).
  localparam logic [21:0] PEND_BASE   = 22'h001000;
  localparam logic [21:0] ENAB_BASE   = 22'h002000;
  localparam logic [21:0] THRESH_ADDR = 22'h200000;
  localparam logic [21:0] CLAIM_ADDR  = 22'h200004;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [21:0] address;
    logic [31:0] write_data;
    logic [4:0]  source_id;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
  } out_beat_t;

  // Finished result offered by the engine to the output register.
  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

endpackage

[design/pic_src_ram.sv]
module pic_src_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 6
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[design/pic_engine.sv]
module pic_engine import pic_pkg::*; #(
  parameter int NUM_SOURCES   = DEF_NUM_SOURCES,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  in_beat_t                       in_beat,
  output res_t                           res,
  input  logic                           take,
  output logic [$clog2(NUM_SOURCES)-1:0] ram_rd_addr,
  input  logic [PRIORITY_BITS+2:0]       ram_rd_data,
  output logic                           ram_we,
  output logic [$clog2(NUM_SOURCES)-1:0] ram_wr_addr,
  output logic [PRIORITY_BITS+2:0]       ram_wr_data
);

  localparam int IW = $clog2(NUM_SOURCES);
  localparam int PB = PRIORITY_BITS;
  localparam int WC = (NUM_SOURCES + 31) / 32;
  localparam logic [21:0] PEND_END = PEND_BASE + 22'(4 * WC);
  localparam logic [21:0] ENAB_END = ENAB_BASE + 22'(4 * WC);
  localparam logic [IW:0] CNT_END  = (IW+1)'(NUM_SOURCES);
  localparam logic [IW:0] CNT_LAST = (IW+1)'(NUM_SOURCES - 1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SWEEP, S_CLAIM, S_DONE} state_t;

  state_t         state;
  logic [IW:0]    cnt;
  logic           proc_vld;
  logic [IW-1:0]  proc_idx;
  in_beat_t       item;
  logic [PB-1:0]  thr;
  logic [IW-1:0]  best_id;
  logic [PB-1:0]  best_prio;
  logic [1:0]     qcount;
  logic [31:0]    rdata;
  logic           irq;

  // Decode of the held item, and of a threshold write on the input beat.
  logic          is_rd, is_wr, is_ev;
  logic          prio_hit, pend_hit, enab_hit, claim_hit;
  logic [9:0]    prio_id;
  logic [4:0]    word_k;
  logic          claim_rd;
  logic          thr_wr_in;

  // Entry under modification.
  logic [10:0]   jx;
  logic [4:0]    j_word, j_bit;
  logic          j_nz;
  logic [PB-1:0] e_prio, n_prio;
  logic          e_pend, e_en, e_ins, n_pend, n_en, n_ins;
  logic          qual, better;
  logic [31:0]   rdata_next;

  always_comb begin
    is_rd     = item.opcode == OP_READ;
    is_wr     = item.opcode == OP_WRITE;
    is_ev     = item.opcode == OP_EVENT;
    prio_hit  = item.address < PEND_BASE;
    pend_hit  = (item.address >= PEND_BASE) && (item.address < PEND_END);
    enab_hit  = (item.address >= ENAB_BASE) && (item.address < ENAB_END);
    claim_hit = item.address == CLAIM_ADDR;
    prio_id   = item.address[11:2];
    word_k    = item.address[6:2];
    claim_rd  = is_rd && claim_hit;
    thr_wr_in = (in_beat.opcode == OP_WRITE) &&
                ({in_beat.address[21:2], 2'b00} == THRESH_ADDR);
  end

  always_comb begin
    jx     = 11'(proc_idx);
    j_word = jx[9:5];
    j_bit  = jx[4:0];
    j_nz   = proc_idx != '0;
    e_prio = ram_rd_data[PB+2:3];
    e_pend = ram_rd_data[2];
    e_en   = ram_rd_data[1];
    e_ins  = ram_rd_data[0];
    n_prio = e_prio;
    n_pend = e_pend;
    n_en   = e_en;
    n_ins  = e_ins;
    rdata_next = rdata;
    if (is_wr && prio_hit && j_nz && (prio_id == jx[9:0])) begin
      n_prio = item.write_data[PB-1:0];
    end
    if (is_wr && enab_hit && (j_word == word_k)) begin
      n_en = j_nz & item.write_data[j_bit];
    end
    if (is_wr && claim_hit && j_nz && e_en && (item.write_data == 32'(proc_idx))) begin
      n_ins = 1'b0;
    end
    if (is_ev && j_nz && (11'(item.source_id) == jx) && !e_pend && !e_ins) begin
      n_pend = 1'b1;
    end
    if (is_rd && prio_hit && (prio_id == jx[9:0])) begin
      rdata_next = 32'(e_prio);
    end
    if (is_rd && pend_hit && (j_word == word_k)) begin
      rdata_next[j_bit] = e_pend;
    end
    if (is_rd && enab_hit && (j_word == word_k)) begin
      rdata_next[j_bit] = e_en;
    end
    qual   = n_pend && n_en && (n_prio > thr);
    better = qual && (n_prio > best_prio);
  end

  // Memory ports: clearing pass, sweep write-back, claim write-back.
  always_comb begin
    ram_rd_addr = cnt[IW-1:0];
    ram_we      = 1'b0;
    ram_wr_addr = cnt[IW-1:0];
    ram_wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SWEEP: begin
        ram_we      = proc_vld;
        ram_wr_addr = proc_idx;
        ram_wr_data = {n_prio, n_pend, n_en, n_ins};
      end
      S_CLAIM: begin
        ram_we      = claim_rd && (qcount != 2'd0);
        ram_wr_addr = best_id;
        ram_wr_data = {best_prio, 1'b0, 1'b1, 1'b1};
      end
      default: begin
      end
    endcase
  end

  assign in_stall       = state != S_IDLE;
  assign res.valid      = state == S_DONE;
  assign res.beat       = '{read_data: rdata, irq_out: irq};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      proc_vld <= 1'b0;
      thr      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= '{opcode:     in_beat.opcode,
                      address:    {in_beat.address[21:2], 2'b00},
                      write_data: in_beat.write_data,
                      source_id:  in_beat.source_id};
            if (thr_wr_in) begin
              thr <= in_beat.write_data[PB-1:0];
            end
            rdata <= (in_beat.opcode == OP_READ &&
                      {in_beat.address[21:2], 2'b00} == THRESH_ADDR) ? 32'(thr) : '0;
            cnt       <= '0;
            proc_vld  <= 1'b0;
            best_id   <= '0;
            best_prio <= '0;
            qcount    <= 2'd0;
            state     <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (cnt != CNT_END) begin
            cnt <= cnt + 1'b1;
          end
          proc_vld <= cnt != CNT_END;
          proc_idx <= cnt[IW-1:0];
          if (proc_vld) begin
            rdata <= rdata_next;
            if (qual && qcount != 2'd2) begin
              qcount <= qcount + 2'd1;
            end
            if (better) begin
              best_id   <= proc_idx;
              best_prio <= n_prio;
            end
            if (cnt == CNT_END) begin
              state <= S_CLAIM;
            end
          end
        end
        S_CLAIM: begin
          if (claim_rd) begin
            rdata <= 32'(best_id);
            irq   <= qcount == 2'd2;
          end else begin
            irq   <= qcount != 2'd0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  a_wb_matches_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && proc_vld) |-> proc_idx == $past(ram_rd_addr))
    else $error("sweep write-back address does not follow the read");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |=> cnt <= CNT_END)
    else $error("sweep counter ran past the last source");

  a_claim_wb: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLAIM && ram_we) |-> (best_id != '0 && claim_rd))
    else $error("claim write-back without a claimed source");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !take) |=> (state == S_DONE && $stable(rdata) && $stable(irq)))
    else $error("offered result changed before it was taken");

endmodule

[design/platform_interrupt_controller_core.sv]
// Single-context platform interrupt controller.
// The input channel (in_valid, in_stall, in_beat) carries one beat per bus
// read, bus write or source event; the output channel (out_valid, out_stall,
// out_beat) returns exactly one beat per input beat, in order, holding the
// read data (the claimed id for a claim read, zero for writes and events)
// and the interrupt line as it stands after that item.
// All per-source state (priority, pending, enable, in-service) lives in one
// synchronous memory of NUM_SOURCES entries. Every item is served by one
// sweep over that memory, an entry read, modified and written back each
// cycle, while the best qualifying source is tracked on the fly. A closing
// step after the sweep settles the interrupt line and, for a claim read,
// writes the claimed entry back.
// With the output register free, out_valid rises at the edge at which the
// engine goes idle, and the engine takes the next beat in the cycle after.
// Items are served one at a time: no new beat is taken until the memory
// sweep and the closing step for the previous item are done.
// A new item is accepted as soon as the previous result has moved into the
// output register, even if the receiver is still stalling it. If the output
// register is still full when a result is ready, the engine waits for it.
// After reset the block clears every memory entry with in_stall high,
// then accepts items.
module platform_interrupt_controller_core import pic_pkg::*; #(
  parameter int NUM_SOURCES   = DEF_NUM_SOURCES,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam int IW = $clog2(NUM_SOURCES);
  localparam int EW = PRIORITY_BITS + 3;

  res_t          res;
  logic          take;
  logic [IW-1:0] ram_rd_addr;
  logic [EW-1:0] ram_rd_data;
  logic          ram_we;
  logic [IW-1:0] ram_wr_addr;
  logic [EW-1:0] ram_wr_data;

  pic_engine #(
    .NUM_SOURCES  (NUM_SOURCES),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .res        (res),
    .take       (take),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data),
    .ram_we     (ram_we),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data)
  );

  pic_src_ram #(
    .DEPTH(NUM_SOURCES),
    .WIDTH(EW)
  ) u_src_ram (
    .clk    (clk),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data),
    .wr_en  (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data)
  );

  // The output register is free when empty or when its beat leaves now.
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && take) begin
      out_beat <= res.beat;
    end
  end

endmodule

[test/platform_interrupt_controller_core_checker.sv]
module platform_interrupt_controller_core_checker import pic_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_beat,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_beat,
  output int        fail_count,
  output int        results_owed
);

  localparam int NSRC  = DEF_NUM_SOURCES;
  localparam int PBITS = DEF_PRIORITY_BITS;

  logic [PBITS-1:0] src_prio [NSRC];
  logic [31:0]      enabled;
  logic [31:0]      pending;
  logic [31:0]      in_service;
  logic [PBITS-1:0] threshold;
  out_beat_t        awaited_responses [$];

  // Lowest id wins a tie because only a strictly higher priority replaces it.
  function automatic logic [31:0] best_claimable();
    logic [31:0]      best;
    logic [PBITS-1:0] best_prio;
    best      = '0;
    best_prio = threshold;
    for (int id = 1; id < NSRC; id++) begin
      if (pending[id] && enabled[id] && src_prio[id] > best_prio) begin
        best_prio = src_prio[id];
        best      = id;
      end
    end
    return best;
  endfunction

  function automatic out_beat_t plic_response(in_beat_t b);
    out_beat_t   r;
    logic [21:0] a;
    logic [31:0] id;
    a           = {b.address[21:2], 2'b00};
    id          = 32'(a[21:2]);
    r.read_data = '0;
    case (b.opcode)
      OP_READ: begin
        if (a < PEND_BASE) begin
          if (id < NSRC) r.read_data = 32'(src_prio[id[4:0]]);
        end else if (a == PEND_BASE) begin
          r.read_data = pending;
        end else if (a == ENAB_BASE) begin
          r.read_data = enabled;
        end else if (a == THRESH_ADDR) begin
          r.read_data = 32'(threshold);
        end else if (a == CLAIM_ADDR) begin
          id = best_claimable();
          if (id != 0) begin
            pending[id[4:0]]    = 1'b0;
            in_service[id[4:0]] = 1'b1;
          end
          r.read_data = id;
        end
      end
      OP_WRITE: begin
        if (a < PEND_BASE) begin
          if (id >= 1 && id < NSRC) src_prio[id[4:0]] = b.write_data[PBITS-1:0];
        end else if (a == ENAB_BASE) begin
          enabled = b.write_data & ~32'd1;
        end else if (a == THRESH_ADDR) begin
          threshold = b.write_data[PBITS-1:0];
        end else if (a == CLAIM_ADDR) begin
          if (b.write_data >= 1 && b.write_data < NSRC && enabled[b.write_data[4:0]])
            in_service[b.write_data[4:0]] = 1'b0;
        end
      end
      OP_EVENT: begin
        if (b.source_id != 0 && !pending[b.source_id] && !in_service[b.source_id])
          pending[b.source_id] = 1'b1;
      end
      default: ;
    endcase
    r.irq_out = (best_claimable() != 0);
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      for (int i = 0; i < NSRC; i++) src_prio[i] = '0;
      enabled    = '0;
      pending    = '0;
      in_service = '0;
      threshold  = '0;
      awaited_responses.delete();
      fail_count   = 0;
      results_owed = 0;
    end else begin
      // A result can never belong to a beat accepted at the same edge.
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result beat, read_data %0h irq_out %0b",
                     $time, out_beat.read_data, out_beat.irq_out);
        end else begin
          want = awaited_responses.pop_front();
          if (out_beat.read_data !== want.read_data)
            report("read_data", want.read_data, out_beat.read_data);
          if (out_beat.irq_out !== want.irq_out)
            report("irq_out", 32'(want.irq_out), 32'(out_beat.irq_out));
        end
      end
      if (in_valid && !in_stall) awaited_responses.push_back(plic_response(in_beat));
      results_owed = awaited_responses.size();
    end
  end

endmodule

[test/platform_interrupt_controller_core_tb.sv]
module platform_interrupt_controller_core_tb;
  import pic_pkg::*;

  // The block treats opcode 3 as a no-op; the package gives it no name.
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int RANDOM_ITEMS = 1300;
  // Long enough for the block to hold one result in its output register,
  // finish the next one and then stall its input for a good while.
  localparam int LONG_HOLD = 400;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;
  int        fail_count;
  int        results_owed;
  bit        sender_calm;
  bit        hold_request;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  platform_interrupt_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  platform_interrupt_controller_core_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_beat      (in_beat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_beat     (out_beat),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // A hang anywhere ends the run here. The figure allows for the slowest
  // legal run (every beat waiting out the longest gaps and stalls, plus the
  // clearing sweep after reset) several times over.
  initial begin
    #25_000_000;
    $display("platform_interrupt_controller_core test failed");
    $finish;
  end

  // Gap before a beat: mostly none or short, now and then a long one.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 90);
  endfunction

  // Register address with random low bits, which the block must ignore.
  function automatic logic [21:0] reg_addr(logic [21:0] a);
    return {a[21:2], 2'($urandom)};
  endfunction

  // Offers one beat and returns at the edge where it is taken. The valid is
  // only lowered when a gap is wanted, so back-to-back beats keep it high.
  task automatic offer(input in_beat_t b);
    int gap;
    gap = sender_calm ? 0 : sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send(input logic [1:0] op, input logic [21:0] addr,
                      input logic [31:0] data, input logic [4:0] src);
    in_beat_t b;
    b.opcode     = op;
    b.address    = addr;
    b.write_data = data;
    b.source_id  = src;
    offer(b);
  endtask

  // The random mix leans on whole interrupt life cycles: sources raise
  // requests, the handler claims them and then completes them. Priority,
  // enable and threshold writes keep moving the goalposts, and a share of
  // reads, stray addresses and no-ops fills in the rest. Every field but the
  // opcode starts out fully random so that all of its bits toggle.
  function automatic in_beat_t random_item();
    in_beat_t b;
    int       pick;
    b.opcode     = OP_READ;
    b.address    = 22'($urandom);
    b.write_data = $urandom;
    b.source_id  = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      b.opcode = OP_EVENT;
    end else if (pick < 48) begin
      b.address = reg_addr(CLAIM_ADDR);
    end else if (pick < 64) begin
      b.opcode  = OP_WRITE;
      b.address = reg_addr(CLAIM_ADDR);
      if ($urandom_range(0, 9) != 0) b.write_data = $urandom_range(1, 31);
    end else if (pick < 72) begin
      b.opcode = OP_WRITE;
      if ($urandom_range(0, 7) == 0) b.address = reg_addr(22'($urandom_range(32, 1023) * 4));
      else b.address = reg_addr(22'($urandom_range(0, 31) * 4));
    end else if (pick < 76) begin
      b.opcode  = OP_WRITE;
      b.address = reg_addr(ENAB_BASE);
      if ($urandom_range(0, 3) != 0) b.write_data = $urandom | $urandom | $urandom;
    end else if (pick < 80) begin
      b.opcode     = OP_WRITE;
      b.address    = reg_addr(THRESH_ADDR);
      b.write_data = ($urandom & 32'hFFFF_FFF8) | $urandom_range(0, 5);
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0:       b.address = reg_addr(22'($urandom_range(0, 31) * 4));
        1:       b.address = reg_addr(PEND_BASE);
        2:       b.address = reg_addr(ENAB_BASE);
        default: b.address = reg_addr(THRESH_ADDR);
      endcase
    end else if (pick < 97) begin
      b.opcode = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    end else begin
      b.opcode = OP_IDLE;
    end
    return b;
  endfunction

  // Receiver side. It picks at random between stretches that never stall and
  // stretches with random stalls, some of them long. Once the stimulus asks
  // for it, it stalls once for the LONG_HOLD span while beats keep coming.
  initial begin : receiver
    int hold_left;
    int mode_left;
    int r;
    bit calm;
    bit held_once;
    hold_left = 0;
    mode_left = 0;
    calm      = 1'b0;
    held_once = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !held_once) begin
        held_once = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          calm      = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
          out_stall <= 1'b0;
        end else begin
          if (r >= 97) hold_left = $urandom_range(20, 80);
          out_stall <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_beat      <= '0;
    sender_calm  = 1'b0;
    hold_request <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Source 5 and source 9 share priority 3, so the first
    // claim must pick the lower id; source 31 gets a wide priority value.
    send(OP_READ,  22'h000000, 32'h0,         5'd0);   // reserved source reads 0
    send(OP_WRITE, 22'h000000, 32'hFFFF_FFFF, 5'd31);  // write to it is dropped
    send(OP_WRITE, 22'h00007C, 32'hFFFF_FFFF, 5'd0);   // wide value keeps 3 bits
    send(OP_WRITE, 22'h000014, 32'h3,         5'd0);
    send(OP_WRITE, 22'h000024, 32'h3,         5'd0);
    send(OP_WRITE, ENAB_BASE,  32'hFFFF_FFFF, 5'd0);
    send(OP_READ,  ENAB_BASE,  32'h0,         5'd0);   // bit 0 must read 0
    send(OP_WRITE, PEND_BASE,  32'hFFFF_FFFF, 5'd0);   // pending is read only
    send(OP_EVENT, 22'h3FFFFF, 32'h0,         5'd0);   // reserved source ignored
    send(OP_EVENT, 22'h000000, 32'h0,         5'd9);
    send(OP_EVENT, 22'h000000, 32'h0,         5'd5);
    send(OP_EVENT, 22'h000000, 32'h0,         5'd5);   // already pending
    send(OP_READ,  PEND_BASE,  32'h0,         5'd0);
    send(OP_WRITE, THRESH_ADDR, 32'hFFFF_FFFA, 5'd0);  // wide threshold
    send(OP_READ,  THRESH_ADDR, 32'h0,        5'd0);
    send(OP_READ,  CLAIM_ADDR | 22'd3, 32'h0, 5'd0);   // unaligned claim
    send(OP_READ,  CLAIM_ADDR, 32'h0,         5'd0);
    send(OP_READ,  CLAIM_ADDR, 32'h0,         5'd0);   // nothing left to claim
    send(OP_EVENT, 22'h000000, 32'h0,         5'd5);   // in service, ignored
    send(OP_WRITE, ENAB_BASE,  32'h0,         5'd0);
    send(OP_WRITE, CLAIM_ADDR, 32'h5,         5'd0);   // disabled, completion lost
    send(OP_WRITE, ENAB_BASE,  32'hFFFF_FFFF, 5'd0);
    send(OP_WRITE, CLAIM_ADDR, 32'h5,         5'd0);
    send(OP_WRITE, CLAIM_ADDR, 32'h25,        5'd0);   // id out of range
    send(OP_READ,  22'h3FFFFC, 32'h0,         5'd0);   // unmapped
    send(OP_WRITE, 22'h3FFFFC, 32'hFFFF_FFFF, 5'd0);
    send(OP_READ,  22'h000204, 32'h0,         5'd0);   // priority of absent source
    send(OP_IDLE,  22'h3FFFFF, 32'hFFFF_FFFF, 5'd31);
    send(OP_WRITE, THRESH_ADDR, 32'h7,        5'd0);
    send(OP_EVENT, 22'h000000, 32'h0,         5'd31);  // priority 7 is not above 7
    send(OP_WRITE, THRESH_ADDR, 32'h0,        5'd0);

    // Random part. Every sixty beats the sender picks anew, at random, between
    // running flat out and leaving random gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      if (n == 100) hold_request <= 1'b1;
      offer(random_item());
    end
    in_valid <= 1'b0;

    // Drain: counts are sampled away from the active edge.
    do @(negedge clk); while (results_owed != 0);
    repeat (4 * (DEF_NUM_SOURCES + 3)) @(posedge clk);

    if (fail_count == 0 && results_owed == 0) begin
      $display("platform_interrupt_controller_core test passed");
    end else begin
      $display("platform_interrupt_controller_core test failed");
    end
    $finish;
  end

endmodule
